// ===== hw/rtl/fwht_pkg.sv =====
// Shared constants, codes and control types of the Walsh-Hadamard transform block.
package fwht_pkg;

	localparam int MAX_LOG_LEN = 6;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ADDR_W = MAX_LOG_LEN;
	localparam int DEPTH = 1 << ADDR_W;
	localparam int CNT_W = ADDR_W + 1;
	localparam int WORD_W = SAMPLE_WIDTH + MAX_LOG_LEN;
	localparam int LOG_W = 3;
	localparam int COEF_W = 19;
	localparam int COEF_MAX = 262143;
	localparam int COEF_MIN = -262144;
	localparam int FRAC_W = 16;
	localparam int KC_W = FRAC_W + 1;
	localparam int PROD_W = WORD_W + KC_W;
	localparam int SUM_W = PROD_W + 1;

	localparam logic [LOG_W-1:0] LOG_LEN_RST = LOG_W'(6);
	localparam logic signed [KC_W-1:0] INV_SQRT2_Q16 = 17'sd46341;

	localparam logic [1:0] WSEL_SAMPLE = 2'd0;
	localparam logic [1:0] WSEL_SUM    = 2'd1;
	localparam logic [1:0] WSEL_DIFF   = 2'd2;

	typedef struct packed {
		logic              we;
		logic [1:0]        wsel;
		logic [ADDR_W-1:0] waddr;
		logic              re;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
		logic              issue;
		logic              issue_last;
	} ctrl_t;

endpackage

// ===== hw/rtl/fast_walsh_hadamard_transform.sv =====
// Top level of the orthonormal fast Walsh-Hadamard transform block.
// Loading: one sample per cycle while busy is low; the last sample raises busy.
// Butterflies: (L/2)*log_len of them on one shared add/sub unit, each a read, a sum write and a difference write.
// Readout: each coefficient is read from the buffer, then passes the scaler product and output registers.
// Results cannot be stalled; a new vector is taken only once the sequencer is back in its load state.
// Reset clears the sequencer and load count and sets log_len to 6; buffer not cleared.
module fast_walsh_hadamard_transform import fwht_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [LOG_W-1:0]               cfg_data,
	output logic                           valid,
	output logic signed [COEF_W-1:0]       coefficient,
	output logic                           last
);

	logic [LOG_W-1:0]         log_len_q;
	logic [LOG_W-1:0]         n;
	logic                     cfg_wr;
	logic                     take;
	ctrl_t                    ctl;
	logic signed [WORD_W-1:0] wdata;
	logic signed [WORD_W-1:0] rd_a;
	logic signed [WORD_W-1:0] rd_b;
	logic                     iss_s1;
	logic                     iss_last_s1;
	logic [COEF_W-1:0]        coef;

	assign n = (log_len_q > LOG_W'(MAX_LOG_LEN)) ? LOG_W'(MAX_LOG_LEN) : log_len_q;
	assign take = start && !busy;
	assign cfg_ready = !busy && !start;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_len_q   <= LOG_LEN_RST;
			iss_s1      <= 1'b0;
			iss_last_s1 <= 1'b0;
		end else begin
			if (cfg_wr) begin
				log_len_q <= cfg_data;
			end
			iss_s1      <= ctl.issue;
			iss_last_s1 <= ctl.issue_last;
		end
	end

	always_comb begin
		case (ctl.wsel)
			WSEL_SUM:  wdata = rd_a + rd_b;
			WSEL_DIFF: wdata = rd_a - rd_b;
			default:   wdata = WORD_W'(sample);
		endcase
	end

	fwht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.n      (n),
		.cfg_wr (cfg_wr),
		.take   (take),
		.busy   (busy),
		.ctl    (ctl)
	);

	fwht_buf u_buf (
		.clk     (clk),
		.we      (ctl.we),
		.waddr   (ctl.waddr),
		.wdata   (wdata),
		.re      (ctl.re),
		.raddr_a (ctl.raddr_a),
		.raddr_b (ctl.raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	fwht_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.n           (n),
		.in_valid    (iss_s1),
		.in_last     (iss_last_s1),
		.v           (rd_a),
		.valid       (valid),
		.last        (last),
		.coefficient (coef)
	);

	assign coefficient = $signed(coef);

endmodule

// ===== hw/rtl/fwht_buf.sv =====
// Work buffer: one write port, two registered read ports.
module fwht_buf import fwht_pkg::*; (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic signed [WORD_W-1:0] wdata,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        raddr_a,
	input  logic [ADDR_W-1:0]        raddr_b,
	output logic signed [WORD_W-1:0] rdata_a,
	output logic signed [WORD_W-1:0] rdata_b
);

	logic signed [WORD_W-1:0] mem_q [DEPTH];
	logic signed [WORD_W-1:0] rd_a_q;
	logic signed [WORD_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== hw/rtl/fwht_scale.sv =====
// Output scaling pipeline: for odd log_len multiply by 1/sqrt2 and round, then shift and saturate.
module fwht_scale import fwht_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [LOG_W-1:0]         n,
	input  logic                     in_valid,
	input  logic                     in_last,
	input  logic signed [WORD_W-1:0] v,
	output logic                     valid,
	output logic                     last,
	output logic [COEF_W-1:0]        coefficient
);

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(COEF_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(COEF_MIN);

	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic                     last_s1;
	logic [1:0]               s;
	logic [4:0]               shamt;
	logic signed [SUM_W-1:0]  rnd;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sh;
	logic [COEF_W-1:0]        coef_d;
	logic                     valid_q;
	logic                     last_q;
	logic [COEF_W-1:0]        coef_q;

	assign s = n[LOG_W-1:1];
	assign shamt = 5'(FRAC_W) + 5'(s);

	always_comb begin
		if (n[0]) begin
			prod_d = v * INV_SQRT2_Q16;
		end else begin
			prod_d = PROD_W'($signed({v, {FRAC_W{1'b0}}}));
		end
	end

	always_comb begin
		if (n[0]) begin
			rnd = SUM_W'(1) << (5'(FRAC_W - 1) + 5'(s));
		end else begin
			rnd = '0;
		end
		sum = SUM_W'(prod_s1) + rnd;
		sh = sum >>> shamt;
		if (sh > SAT_HI) begin
			coef_d = COEF_W'(SAT_HI);
		end else if (sh < SAT_LO) begin
			coef_d = COEF_W'(SAT_LO);
		end else begin
			coef_d = sh[COEF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			vld_s1  <= in_valid;
			last_s1 <= in_valid && in_last;
			valid_q <= vld_s1;
			last_q  <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
		coef_q  <= coef_d;
	end

	assign valid = valid_q;
	assign last = last_q;
	assign coefficient = coef_q;

endmodule

// ===== hw/rtl/fwht_ctrl.sv =====
// Sequencer: sample loading, butterfly addressing and output readout.
module fwht_ctrl import fwht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LOG_W-1:0] n,
	input  logic             cfg_wr,
	input  logic             take,
	output logic             busy,
	output ctrl_t            ctl
);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_WA   = 3'd2;
	localparam logic [2:0] ST_WB   = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_DR1  = 3'd5;
	localparam logic [2:0] ST_DR2  = 3'd6;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  load_q;
	logic [LOG_W-1:0]  st_q;
	logic [ADDR_W-1:0] k_q;
	logic [ADDR_W-1:0] idx_q;

	logic [CNT_W-1:0]  len;
	logic [CNT_W-1:0]  load_nxt;
	logic [ADDR_W-1:0] len_m1;
	logic [ADDR_W-1:0] half_m1;
	logic [LOG_W-1:0]  n_m1;
	logic [LOG_W-1:0]  p;
	logic [ADDR_W-1:0] stride;
	logic [ADDR_W-1:0] mask;
	logic [ADDR_W-1:0] j;
	logic              k_last;
	logic              st_last;

	assign len = CNT_W'(1) << n;
	assign load_nxt = load_q + CNT_W'(1);
	assign len_m1 = ADDR_W'(len - CNT_W'(1));
	assign half_m1 = ADDR_W'((len >> 1) - CNT_W'(1));
	assign n_m1 = n - LOG_W'(1);
	assign p = n_m1 - st_q;
	assign stride = ADDR_W'(1) << p;
	assign mask = stride - ADDR_W'(1);
	assign j = ((k_q & ~mask) << 1) | (k_q & mask);
	assign k_last = (k_q == half_m1);
	assign st_last = (st_q == n_m1);
	assign busy = (state_q != ST_LOAD);

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_LOAD: begin
				ctl.we    = take;
				ctl.wsel  = WSEL_SAMPLE;
				ctl.waddr = load_q[ADDR_W-1:0];
			end
			ST_RD: begin
				ctl.re      = 1'b1;
				ctl.raddr_a = j;
				ctl.raddr_b = j | stride;
			end
			ST_WA: begin
				ctl.we    = 1'b1;
				ctl.wsel  = WSEL_SUM;
				ctl.waddr = j;
			end
			ST_WB: begin
				ctl.we    = 1'b1;
				ctl.wsel  = WSEL_DIFF;
				ctl.waddr = j | stride;
			end
			ST_OUT: begin
				ctl.re         = 1'b1;
				ctl.raddr_a    = idx_q;
				ctl.issue      = 1'b1;
				ctl.issue_last = (idx_q == len_m1);
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q  <= '0;
			st_q    <= '0;
			k_q     <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (cfg_wr) begin
						load_q <= '0;
					end else if (take) begin
						if (load_nxt == len) begin
							load_q  <= '0;
							st_q    <= '0;
							k_q     <= '0;
							idx_q   <= '0;
							state_q <= (n == '0) ? ST_OUT : ST_RD;
						end else begin
							load_q <= load_nxt;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_WA;
				end
				ST_WA: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (k_last) begin
						k_q <= '0;
						if (st_last) begin
							state_q <= ST_OUT;
						end else begin
							st_q    <= st_q + LOG_W'(1);
							state_q <= ST_RD;
						end
					end else begin
						k_q     <= k_q + ADDR_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_OUT: begin
					idx_q <= idx_q + ADDR_W'(1);
					if (idx_q == len_m1) begin
						state_q <= ST_DR1;
					end
				end
				ST_DR1: begin
					state_q <= ST_DR2;
				end
				ST_DR2: begin
					state_q <= ST_LOAD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.we && ctl.re))
		else $error("buffer read and write in the same cycle");

	a_pair_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (ctl.raddr_a != ctl.raddr_b))
		else $error("butterfly pair reads one entry twice");

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (load_q < len))
		else $error("load count reached vector length while loading");

	a_sum_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WA) |-> ($past(state_q) == ST_RD))
		else $error("butterfly write without preceding read");

endmodule
